// File: rtl/bilinear_resize_short_side_macros.svh
// Assertion helpers shared by the divider and the top-level RTL files.
`ifndef BILINEAR_RESIZE_SHORT_SIDE_MACROS_SVH
`define BILINEAR_RESIZE_SHORT_SIDE_MACROS_SVH

// Same-cycle implication.
`define BRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/brs_pkg.sv
package brs_pkg;

	localparam int CFG_W      = 9;
	localparam int NC_W       = 2;
	localparam int COORD_W    = 15;
	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 16;
	localparam int QUO_W      = 25;
	localparam int DIVIDEND_W = 40;
	localparam int DIVISOR_W  = 15;

	localparam logic [COORD_W-1:0] LIMIT15 = 15'h7fff;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_SRC_HEIGHT   = 2'd0;
	localparam logic [1:0] REG_SRC_WIDTH    = 2'd1;
	localparam logic [1:0] REG_NUM_CHANNELS = 2'd2;
	localparam logic [1:0] REG_SHORT_SIDE   = 2'd3;

endpackage

// File: rtl/brs_div.sv
// Restoring divider, one quotient bit per cycle. Caller guarantees
// dividend < divisor * 2**QUO_W.
module brs_div
	import brs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [QUO_W-1:0]      quotient
);
`include "bilinear_resize_short_side_macros.svh"

	localparam int CNT_W = $clog2(QUO_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [QUO_W-1:0]     dvd_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [QUO_W-1:0]     quo_q;

	logic [DIVISOR_W:0] trial;
	logic               ge;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses for one cycle after the last step
			done_q <= !start && busy_q && (cnt_q == CNT_W'(QUO_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIVIDEND_W-1:QUO_W];
			dvd_q <= dividend[QUO_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIVISOR_W'(trial - {1'b0, den_q}) : trial[DIVISOR_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`BRS_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy_q, "divider started while busy")
	`BRS_ASSERT_IMP(a_cnt_bound, clk, arst_n, busy_q, cnt_q <= CNT_W'(QUO_W - 1), "step count overrun")
	`BRS_ASSERT_NEXT(a_done_idle, clk, arst_n, done_q, !done_q, "done held more than one cycle")

endmodule

// File: rtl/brs_store.sv
// Sample store: one write port, one registered read port.
module brs_store
	import brs_pkg::*;
#(
	parameter int DEPTH = 196608
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic signed [SAMPLE_W-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic signed [SAMPLE_W-1:0] rdata
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/bilinear_resize_short_side.sv
// Bilinear resize to a set short side, corners aligned.
// Input channel (valid/ready): op selects load or query. A load writes one
// source sample into the store and gives no result; loads are taken one per
// cycle while no query is in flight. A query returns one result on the output
// channel: the interpolated value, a status (1 = channel or coordinate out of
// range, value 0) and the resized image height and width.
// An in-range query uses three 25-step runs of the shared one-bit-per-cycle
// divider (long side, row position, column position) and four store reads on
// the single read port; an out-of-range query finishes after the first run.
// One query is in flight at a time. A finished result sits in the output
// register; the block accepts the next item while it waits, and a further
// query stalls in its last step until the receiver takes the result.
// Config port (valid/ready, always ready) writes a register by index; write
// only while the block is idle.
// Reset clears control state and loads the register defaults; the sample
// store is not cleared and must be loaded before it is queried.
module bilinear_resize_short_side
	import brs_pkg::*;
#(
	parameter int MAX_SIDE     = 256,
	parameter int MAX_CHANNELS = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [NC_W-1:0]            channel,
	input  logic [COORD_W-1:0]         row,
	input  logic [COORD_W-1:0]         col,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] value,
	output logic                       status,
	output logic [COORD_W-1:0]         target_height,
	output logic [COORD_W-1:0]         target_width,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);
`include "bilinear_resize_short_side_macros.svh"

	localparam int DEPTH  = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SIZE, ST_SIZE_WAIT, ST_CHECK, ST_ROW_DIV, ST_ROW_WAIT,
		ST_COL_DIV, ST_COL_WAIT, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
		ST_MUL1, ST_MUL2, ST_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] src_height_q, src_width_q, short_side_q;
	logic [NC_W-1:0]  num_channels_q;

	// clamped configuration
	logic [CFG_W-1:0] h, w, s, lng_src, sht_src;
	logic [NC_W-1:0]  nc;

	// latched query
	logic [NC_W-1:0]    ch_q;
	logic [COORD_W-1:0] row_q, col_q;
	logic [COORD_W-1:0] th_q, tw_q;
	logic [23:0]        rowp_q, colp_q;
	logic               err_q;
	logic               err_n;
	logic [CFG_W-1:0]   y0_q, y1_q, x0_q, x1_q;
	logic [FRAC_W-1:0]  fy_q, fx_q;

	logic signed [SAMPLE_W-1:0] s00_q, s01_q, s10_q, s11_q;
	logic signed [33:0]         top_q, bot_q;
	logic signed [51:0]         acc_q;

	// load write stage
	logic                       we_q;
	logic [ADDR_W-1:0]          waddr_q;
	logic signed [SAMPLE_W-1:0] wdata_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic                       status_q;
	logic [COORD_W-1:0]         th_out_q, tw_out_q;

	// divider hookup
	logic                  div_start, div_done;
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [DIVISOR_W-1:0]  div_divisor;
	logic [QUO_W-1:0]      div_quo;

	logic [ADDR_W-1:0]          raddr;
	logic signed [SAMPLE_W-1:0] rdata;

	function automatic logic [ADDR_W-1:0] store_addr(input logic [NC_W-1:0] c,
			input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] x);
		store_addr = ADDR_W'(c) * ADDR_W'(MAX_SIDE * MAX_SIDE)
			+ ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(x);
	endfunction

	always_comb begin
		if (src_height_q < CFG_W'(2)) h = CFG_W'(2);
		else if (32'(src_height_q) > MAX_SIDE) h = CFG_W'(MAX_SIDE);
		else h = src_height_q;
		if (src_width_q < CFG_W'(2)) w = CFG_W'(2);
		else if (32'(src_width_q) > MAX_SIDE) w = CFG_W'(MAX_SIDE);
		else w = src_width_q;
		if (num_channels_q == '0) nc = NC_W'(1);
		else if (32'(num_channels_q) > MAX_CHANNELS) nc = NC_W'(MAX_CHANNELS);
		else nc = num_channels_q;
		s = (short_side_q < CFG_W'(2)) ? CFG_W'(2) : short_side_q;
		// equal sides: the height is the short side
		lng_src = (h > w) ? h : w;
		sht_src = (h > w) ? w : h;
	end

	// divider operand select
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_SIZE: begin
				div_start    = 1'b1;
				div_dividend = DIVIDEND_W'(18'(lng_src) * 18'(s));
				div_divisor  = DIVISOR_W'(sht_src);
			end
			ST_ROW_DIV: begin
				div_start    = 1'b1;
				div_dividend = {rowp_q, {FRAC_W{1'b0}}};
				div_divisor  = th_q - 1'b1;
			end
			ST_COL_DIV: begin
				div_start    = 1'b1;
				div_dividend = {colp_q, {FRAC_W{1'b0}}};
				div_divisor  = tw_q - 1'b1;
			end
			default: ;
		endcase
	end

	brs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// axis mapping from quotient: integer part and 16-bit fraction;
	// at the last source index the neighbor is held with weight zero
	logic [CFG_W-1:0] q_base;
	logic             y_last, x_last;
	assign q_base = div_quo[QUO_W-1:FRAC_W];
	assign y_last = q_base >= (h - 1'b1);
	assign x_last = q_base >= (w - 1'b1);

	// range check against the freshly computed target sizes
	assign err_n = ch_q >= nc || row_q >= th_q || col_q >= tw_q;

	// read address: RD0 y0/x0, RD1 y0/x1, RD2 y1/x0, RD3 y1/x1
	always_comb begin
		logic [CFG_W-1:0] ry, rx;
		ry = (state_q == ST_RD0 || state_q == ST_RD1) ? y0_q : y1_q;
		rx = (state_q == ST_RD0 || state_q == ST_RD2) ? x0_q : x1_q;
		raddr = store_addr(ch_q, COORD_W'(ry), COORD_W'(rx));
	end

	brs_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we_q),
		.waddr (waddr_q),
		.wdata (wdata_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// interpolation arithmetic
	logic signed [16:0] d_top, d_bot;
	logic signed [33:0] top_n, bot_n;
	logic signed [34:0] d_v;
	logic signed [51:0] acc_n, acc_rnd;
	logic signed [19:0] rnd;
	logic signed [SAMPLE_W-1:0] rnd_sat;

	always_comb begin
		d_top = 17'(s01_q) - 17'(s00_q);
		d_bot = 17'(s11_q) - 17'(s10_q);
		top_n = (34'(s00_q) <<< FRAC_W) + 34'(d_top) * 34'($signed({1'b0, fx_q}));
		bot_n = (34'(s10_q) <<< FRAC_W) + 34'(d_bot) * 34'($signed({1'b0, fx_q}));
		d_v   = 35'(bot_q) - 35'(top_q);
		acc_n = (52'(top_q) <<< FRAC_W) + 52'(d_v) * 52'($signed({1'b0, fy_q}));
		// round half up
		acc_rnd = acc_q + (52'sd1 <<< 31);
		rnd     = acc_rnd[51:32];
		if (rnd > 20'sd32767) rnd_sat = 16'sh7fff;
		else if (rnd < -20'sd32768) rnd_sat = -16'sh8000;
		else rnd_sat = rnd[SAMPLE_W-1:0];
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			src_height_q   <= CFG_W'(256);
			src_width_q    <= CFG_W'(256);
			num_channels_q <= NC_W'(3);
			short_side_q   <= CFG_W'(224);
			we_q           <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SRC_HEIGHT:   src_height_q   <= cfg_data;
					REG_SRC_WIDTH:    src_width_q    <= cfg_data;
					REG_NUM_CHANNELS: num_channels_q <= cfg_data[NC_W-1:0];
					REG_SHORT_SIDE:   short_side_q   <= cfg_data;
					default: ;
				endcase
			end
			// out-of-image loads are dropped
			we_q <= state_q == ST_IDLE && in_valid && op == OP_LOAD &&
				channel < nc && row < COORD_W'(h) && col < COORD_W'(w);
			// result held until taken; a new one loads when the register is free
			out_valid_q <= (state_q == ST_FINISH && out_free) ||
				(out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && op == OP_QUERY) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE:      state_q <= ST_SIZE_WAIT;
				ST_SIZE_WAIT: if (div_done) state_q <= ST_CHECK;
				ST_CHECK:     state_q <= err_n ? ST_FINISH : ST_ROW_DIV;
				ST_ROW_DIV:   state_q <= ST_ROW_WAIT;
				ST_ROW_WAIT:  if (div_done) state_q <= ST_COL_DIV;
				ST_COL_DIV:   state_q <= ST_COL_WAIT;
				ST_COL_WAIT:  if (div_done) state_q <= ST_RD0;
				ST_RD0:       state_q <= ST_RD1;
				ST_RD1:       state_q <= ST_RD2;
				ST_RD2:       state_q <= ST_RD3;
				ST_RD3:       state_q <= ST_RD4;
				ST_RD4:       state_q <= ST_MUL1;
				ST_MUL1:      state_q <= ST_MUL2;
				ST_MUL2:      state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				waddr_q <= store_addr(channel, row, col);
				wdata_q <= sample;
				ch_q    <= channel;
				row_q   <= row;
				col_q   <= col;
			end
			ST_SIZE_WAIT: begin
				if (div_done) begin
					if (h > w) begin
						th_q <= (div_quo > QUO_W'(LIMIT15)) ? LIMIT15 : div_quo[COORD_W-1:0];
						tw_q <= COORD_W'(s);
					end else begin
						th_q <= COORD_W'(s);
						tw_q <= (div_quo > QUO_W'(LIMIT15)) ? LIMIT15 : div_quo[COORD_W-1:0];
					end
				end
			end
			ST_CHECK: begin
				rowp_q <= 24'(row_q) * 24'(h - 1'b1);
				colp_q <= 24'(col_q) * 24'(w - 1'b1);
			end
			ST_ROW_WAIT: begin
				if (div_done) begin
					y0_q <= y_last ? h - 1'b1 : q_base;
					y1_q <= y_last ? h - 1'b1 : q_base + 1'b1;
					fy_q <= y_last ? '0 : div_quo[FRAC_W-1:0];
				end
			end
			ST_COL_WAIT: begin
				if (div_done) begin
					x0_q <= x_last ? w - 1'b1 : q_base;
					x1_q <= x_last ? w - 1'b1 : q_base + 1'b1;
					fx_q <= x_last ? '0 : div_quo[FRAC_W-1:0];
				end
			end
			ST_RD1:  s00_q <= rdata;
			ST_RD2:  s01_q <= rdata;
			ST_RD3:  s10_q <= rdata;
			ST_RD4:  s11_q <= rdata;
			ST_MUL1: begin
				top_q <= top_n;
				bot_q <= bot_n;
			end
			ST_MUL2: acc_q <= acc_n;
			ST_FINISH: begin
				if (out_free) begin
					value_q  <= err_q ? '0 : rnd_sat;
					status_q <= err_q;
					th_out_q <= th_q;
					tw_out_q <= tw_q;
				end
			end
			default: ;
		endcase
	end

	// range check flag, taken once the target sizes are known
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			err_q <= err_n;
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign value         = value_q;
	assign status        = status_q;
	assign target_height = th_out_q;
	assign target_width  = tw_out_q;

	`BRS_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && in_ready && op == OP_QUERY, !in_ready, "query transfer did not leave idle")
	`BRS_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status, value == '0, "error result carries nonzero value")
	`BRS_ASSERT_IMP(a_done_wait, clk, arst_n, div_done, state_q == ST_SIZE_WAIT || state_q == ST_ROW_WAIT || state_q == ST_COL_WAIT, "divider result outside a wait state")

endmodule

// File: sim/bilinear_resize_short_side_tb.sv
module bilinear_resize_short_side_tb;
	import brs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE      = 256;
	localparam int PLANES    = 3;
	localparam int MEM_DEPTH = PLANES * SIDE * SIDE;
	// settle wait, with margin for an item still in the pipe
	localparam int SETTLE    = 150;
	localparam int MAX_CYCLES = 1_000_000;

	typedef struct {
		logic                       op;
		logic [NC_W-1:0]            ch;
		logic [COORD_W-1:0]         r;
		logic [COORD_W-1:0]         c;
		logic signed [SAMPLE_W-1:0] smp;
	} pixel_item_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       status;
		logic [COORD_W-1:0]         th;
		logic [COORD_W-1:0]         tw;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic op = OP_LOAD;
	logic [NC_W-1:0] channel = '0;
	logic [COORD_W-1:0] row = '0, col = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] value;
	logic status;
	logic [COORD_W-1:0] target_height, target_width;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [1:0] cfg_index = REG_SRC_HEIGHT;
	logic [CFG_W-1:0] cfg_data = '0;

	bilinear_resize_short_side u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the config registers (raw, as written) and of the sample store
	logic [CFG_W-1:0] reg_h = 9'd256, reg_w = 9'd256, reg_s = 9'd224;
	logic [NC_W-1:0]  reg_nc = 2'd3;
	logic signed [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];

	pixel_item_t   pending_items[$];
	pixel_result_t expected_pixels[$];

	bit gaps_on = 1'b1;
	int mismatches = 0;
	int queries_sent = 0, loads_sent = 0, results_seen = 0, oob_seen = 0;
	int cycles = 0;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// effective image geometry after clamping, and the resized dimensions
	function automatic void image_geometry(output int hc, output int wc, output int ncc,
			output int th, output int tw);
		longint lng;
		int s;
		hc  = clampi(reg_h, 2, SIDE);
		wc  = clampi(reg_w, 2, SIDE);
		ncc = clampi(reg_nc, 1, PLANES);
		s   = clampi(reg_s, 2, 511);
		if (hc > wc) begin
			lng = longint'(hc) * s / wc;
			th  = lng > 32767 ? 32767 : int'(lng);
			tw  = s;
		end else begin
			lng = longint'(wc) * s / hc;
			th  = s;
			tw  = lng > 32767 ? 32767 : int'(lng);
		end
	endfunction

	// corner-aligned mapping of a target index onto one source axis
	function automatic void source_position(input int t, input int src, input int tgt,
			output int lo, output int hi, output longint frac);
		longint num, den, base;
		num  = longint'(t) * (src - 1);
		den  = tgt - 1;
		base = num / den;
		if (base >= src - 1) begin
			lo = src - 1;
			hi = src - 1;
			frac = 0;
		end else begin
			lo = int'(base);
			hi = int'(base) + 1;
			frac = ((num % den) << 16) / den;
		end
	endfunction

	function automatic longint stored(int ch, int r, int c);
		return longint'(sample_mem[(ch * SIDE + r) * SIDE + c]);
	endfunction

	// applies one accepted item to the shadow store; returns 1 with a result for a query
	function automatic bit resize_pixel(input pixel_item_t it, output pixel_result_t res);
		int hc, wc, ncc, th, tw, y0, y1, x0, x1;
		longint fy, fx, top, bot, acc, q;
		image_geometry(hc, wc, ncc, th, tw);
		if (it.op == OP_LOAD) begin
			if (it.ch < ncc && it.r < hc && it.c < wc)
				sample_mem[(it.ch * SIDE + it.r) * SIDE + it.c] = it.smp;
			return 1'b0;
		end
		res.th = th[COORD_W-1:0];
		res.tw = tw[COORD_W-1:0];
		if (it.ch >= ncc || it.r >= th || it.c >= tw) begin
			res.value  = '0;
			res.status = 1'b1;
			return 1'b1;
		end
		source_position(it.r, hc, th, y0, y1, fy);
		source_position(it.c, wc, tw, x0, x1, fx);
		top = stored(it.ch, y0, x0) * (65536 - fx) + stored(it.ch, y0, x1) * fx;
		bot = stored(it.ch, y1, x0) * (65536 - fx) + stored(it.ch, y1, x1) * fx;
		acc = top * (65536 - fy) + bot * fy;
		// round half up; arithmetic shift floors negatives
		q = (acc + (longint'(1) << 31)) >>> 32;
		q = q > 32767 ? 32767 : (q < -32768 ? -32768 : q);
		res.value  = q[SAMPLE_W-1:0];
		res.status = 1'b0;
		return 1'b1;
	endfunction

	// driver: holds the payload until the transfer, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		pixel_item_t it;
		pixel_result_t exp_res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				it = '{op, channel, row, col, sample};
				if (resize_pixel(it, exp_res)) begin
					expected_pixels.push_back(exp_res);
					queries_sent++;
				end else begin
					loads_sent++;
				end
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && !(gaps_on && $urandom_range(99) < 6)) begin
					it = pending_items.pop_front();
					op       <= it.op;
					channel  <= it.ch;
					row      <= it.r;
					col      <= it.c;
					sample   <= it.smp;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, compare each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result value=%0d status=%0d",
							value, status);
				end else begin
					e = expected_pixels.pop_front();
					if (e.status) oob_seen++;
					if (value !== e.value || status !== e.status ||
							target_height !== e.th || target_width !== e.tw) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result exp v=%0d s=%0d h=%0d w=%0d got v=%0d s=%0d h=%0d w=%0d",
								e.value, e.status, e.th, e.tw,
								value, status, target_height, target_width);
					end
				end
			end
			out_ready <= !(gaps_on && $urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("bilinear_resize_short_side_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input int data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SRC_HEIGHT:   reg_h  = data[CFG_W-1:0];
			REG_SRC_WIDTH:    reg_w  = data[CFG_W-1:0];
			REG_NUM_CHANNELS: reg_nc = data[NC_W-1:0];
			REG_SHORT_SIDE:   reg_s  = data[CFG_W-1:0];
		endcase
	endtask

	// every result back; the settle that callers add covers a load still in the pipe
	task automatic wait_results_drained();
		while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
	endtask

	task automatic push_item(logic o, int ch, int r, int c, int smp);
		pixel_item_t it;
		it = '{o, ch[NC_W-1:0], r[COORD_W-1:0], c[COORD_W-1:0], smp[SAMPLE_W-1:0]};
		pending_items.push_back(it);
	endtask

	// reconfigure, then optionally fill the whole (clamped) image so no query
	// reads an unwritten entry
	task automatic start_image(int h, int w, int nc, int s, bit fill);
		int hc, wc, ncc, th, tw;
		wait_results_drained();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_SRC_HEIGHT, h);
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_NUM_CHANNELS, nc);
		write_reg(REG_SHORT_SIDE, s);
		image_geometry(hc, wc, ncc, th, tw);
		if (fill)
			for (int ch = 0; ch < ncc; ch++)
				for (int r = 0; r < hc; r++)
					for (int c = 0; c < wc; c++)
						push_item(OP_LOAD, ch, r, c, $urandom);
	endtask

	// height clamps down to 256 and the long side saturates; only the source
	// rows that the chosen target rows touch are loaded
	task automatic tall_clamped_image();
		int fill_rows[4];
		int query_rows[5];
		fill_rows  = '{0, 1, 254, 255};
		query_rows = '{0, 1, 2, 32765, 32766};
		start_image(300, 2, 1, 511, 1'b0);
		foreach (fill_rows[i])
			for (int c = 0; c < 2; c++)
				push_item(OP_LOAD, 0, fill_rows[i], c, $urandom);
		push_item(OP_LOAD, 0, 256, 0, 1234);      // past the clamped height, ignored
		push_item(OP_LOAD, 0, 299, 1, 1234);      // below the raw height, still ignored
		foreach (query_rows[i]) begin
			push_item(OP_QUERY, 0, query_rows[i], 0, 0);
			push_item(OP_QUERY, 0, query_rows[i], $urandom_range(509), 0);
			push_item(OP_QUERY, 0, query_rows[i], 510, 0);
		end
		push_item(OP_QUERY, 0, 32767, 0, 0);      // row just past
		push_item(OP_QUERY, 0, 0, 511, 0);        // col just past
		push_item(OP_QUERY, 1, 0, 0, 0);          // plane beyond the count
	endtask

	// mostly in-range queries; some out-of-range queries and loads of any kind
	task automatic random_items(int n, bit pause_midway);
		int hc, wc, ncc, th, tw, k;
		image_geometry(hc, wc, ncc, th, tw);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2) wait_results_drained();
			k = $urandom_range(99);
			if (k < 65)
				push_item(OP_QUERY, $urandom_range(ncc - 1), $urandom_range(th - 1),
					$urandom_range(tw - 1), $urandom);
			else if (k < 78)
				push_item(OP_QUERY, $urandom_range(3), $urandom_range(32767),
					$urandom_range(32767), $urandom);
			else if (k < 92)
				push_item(OP_LOAD, $urandom_range(ncc - 1), $urandom_range(hc - 1),
					$urandom_range(wc - 1), $urandom);
			else
				push_item(OP_LOAD, $urandom_range(3), $urandom_range(32767),
					$urandom_range(32767), $urandom);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: 3x5 source, 3 planes, short side 4 -> 4x6 target
		start_image(3, 5, 3, 4, 1'b1);
		push_item(OP_LOAD, 0, 0, 0, -32768);
		push_item(OP_LOAD, 0, 0, 1, 32767);
		push_item(OP_LOAD, 0, 1, 0, 32767);
		push_item(OP_LOAD, 0, 1, 1, -32768);
		push_item(OP_LOAD, 3, 0, 0, 1234);        // plane out of range, ignored
		push_item(OP_LOAD, 0, 32767, 0, 1234);    // row out of range, ignored
		push_item(OP_LOAD, 0, 0, 32767, 1234);    // col out of range, ignored
		push_item(OP_QUERY, 0, 0, 0, 0);          // corner
		push_item(OP_QUERY, 0, 1, 1, 0);          // mixed extremes
		push_item(OP_QUERY, 2, 3, 5, 0);          // far corner, last row and col
		push_item(OP_QUERY, 1, 3, 2, 0);          // last row
		push_item(OP_QUERY, 1, 2, 5, 0);          // last column
		push_item(OP_QUERY, 0, 2, 3, -1);
		push_item(OP_QUERY, 3, 0, 0, 0);          // bad plane
		push_item(OP_QUERY, 0, 4, 0, 0);          // row just past
		push_item(OP_QUERY, 0, 0, 6, 0);          // col just past
		push_item(OP_QUERY, 0, 32767, 32767, 0);
		random_items(60, 1'b1);

		// tall, narrow, height above range: long side saturates
		tall_clamped_image();

		// wide, flat, smallest short side; no idling on either side
		gaps_on = 1'b0;
		start_image(2, 40, 1, 2, 1'b1);
		random_items(60, 1'b0);
		wait_results_drained();
		gaps_on = 1'b1;

		// register values below range clamp up
		start_image(1, 3, 0, 1, 1'b1);
		random_items(50, 1'b0);

		// equal sides
		start_image(5, 5, 2, 9, 1'b1);
		random_items(40, 1'b0);

		for (int p = 0; p < 3; p++) begin
			start_image($urandom_range(2, 6), $urandom_range(2, 6),
				$urandom_range(1, 3), $urandom_range(2, 40), 1'b1);
			random_items(30, 1'b0);
		end

		wait_results_drained();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d loads and %0d queries (%0d out of range), %0d results checked",
			loads_sent, queries_sent, oob_seen, results_seen);
		$display("geometries: clamped registers, saturated long side, equal sides, 1..3 planes");
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("bilinear_resize_short_side_tb: done, clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_pixels.size());
			$display("bilinear_resize_short_side_tb: done, errors");
		end
		$finish;
	end

endmodule
